// ===== rtl/cgli_pkg.sv =====
// Shared widths, types and constants of the column gap interpolator.
`timescale 1ns / 1ps
package cgli_pkg;

  localparam int VAL_W  = 24;  // Q15.8 pixel value
  localparam int LAT_W  = 28;  // latitude in microdegrees
  localparam int ROW_W  = 13;  // row index on the result channel
  localparam int DV_W   = VAL_W + 1;
  localparam int DL_W   = LAT_W + 1;
  localparam int PROD_W = DV_W + DL_W;
  localparam int MAG_W  = PROD_W - 1;
  localparam int DEN_W  = DL_W;
  localparam int SUM_W  = PROD_W + 2;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 24'sh7FFFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 24'sh800000;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [LAT_W-1:0] lat_t;
  typedef logic [ROW_W-1:0]        row_t;

  typedef struct packed {
    row_t row;
    lat_t lat;
  } gap_entry_t;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

endpackage

// ===== rtl/cgli_gap_mem.sv =====
// Gap buffer memory: rows and latitudes of held pixels, one write and one read port.
`timescale 1ns / 1ps
module cgli_gap_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  cgli_pkg::gap_entry_t wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output cgli_pkg::gap_entry_t rd_data
);
  import cgli_pkg::*;

  gap_entry_t mem [DEPTH];
  gap_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/cgli_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
`timescale 1ns / 1ps
module cgli_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cgli_pkg::div_req_t            req,
  output logic                          done,
  output logic [cgli_pkg::MAG_W-1:0]    quot
);
  import cgli_pkg::*;

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [MAG_W-1:0] q_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;

  always_comb begin
    rem_sh  = {rem_r, q_r[MAG_W-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_sub = rem_sh - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        q_r    <= req.num;
        den_r  <= req.den;
        rem_r  <= '0;
      end else if (busy_r) begin
        // The remainder stays below the divisor, so its top bit drops safely.
        rem_r <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        q_r   <= {q_r[MAG_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MAG_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== rtl/column_gap_linear_interpolator_core.sv =====
// Top level of the column gap interpolator: control sequencer and result register.
//
//  Channel | Direction | Handshake          | Word
//  in_     | input     | in_valid/in_ready  | pixel value, flags, latitude
//  out_    | output    | out_valid/out_ready| row, filled value, flags
//
// A land, valid or overflowing pixel with nothing held runs S_IDLE and S_PIX;
// a missing pixel is written to the gap buffer in S_IDLE. A flushed pixel runs
// S_FRD and S_FOUT; a held pixel filled by interpolation runs S_GRD, S_GMUL,
// S_GDIV, S_GWAIT (on the one-bit-per-cycle divider) and S_GOUT; a copied fill skips S_GDIV and S_GWAIT.
// Reset is synchronous and clears control state; the gap buffer is not cleared.
// The input is taken whenever the sequencer is idle, even with a word waiting
// on the output; a stalled output holds the sequencer at its next result.
`timescale 1ns / 1ps
module column_gap_linear_interpolator_core #(
  parameter int MAX_GAP  = 32,
  parameter int MAX_ROWS = 8192
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cgli_pkg::val_t       in_pixel_value,
  input  logic                 in_value_present,
  input  cgli_pkg::lat_t       in_latitude,
  input  logic                 in_is_land,
  input  logic                 in_column_end,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cgli_pkg::row_t       out_row_index,
  output cgli_pkg::val_t       out_result_value,
  output logic                 out_result_present,
  output logic                 out_gap_overflow,
  output logic                 out_last_of_run
);
  import cgli_pkg::*;

  localparam int IDX_W = $clog2(MAX_GAP);
  localparam int CNT_W = $clog2(MAX_GAP + 1);
  localparam int RC_W  = $clog2(MAX_ROWS);

  typedef enum logic [3:0] {
    S_IDLE, S_PIX, S_GRD, S_GMUL, S_GDIV, S_GWAIT, S_GOUT, S_FRD, S_FOUT
  } state_t;

  state_t           state_r;
  val_t             val_r;
  logic             pres_r;
  lat_t             lat_r;
  logic             land_r;
  logic             cend_r;
  row_t             row_r;
  logic [RC_W-1:0]  rowc_r;
  logic             have_left_r;
  val_t             left_val_r;
  lat_t             left_lat_r;
  logic [CNT_W-1:0] count_r;
  logic [IDX_W-1:0] k_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [DEN_W-1:0]  den_r;
  val_t             fill_r;

  logic             out_valid_r;
  row_t             out_row_r;
  val_t             out_val_r;
  logic             out_pres_r;
  logic             out_ovf_r;
  logic             out_last_r;

  logic             accept;
  logic             slot_free;
  logic             k_last;
  logic             pix_last;
  logic [RC_W-1:0]  rowc_nxt;
  row_t             row_lo;
  logic signed [DV_W-1:0]   dv;
  logic signed [DL_W-1:0]   dl;
  logic signed [DEN_W-1:0]  den_w;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_neg;
  logic signed [DEN_W-1:0]  den_neg;
  logic signed [SUM_W-1:0]  qs;
  logic signed [SUM_W-1:0]  sum;
  val_t             interp;

  logic             mem_wr_en;
  logic             mem_rd_en;
  gap_entry_t       mem_wr_data;
  gap_entry_t       mem_rd_data;
  div_req_t         div_req;
  logic             div_done;
  logic [MAG_W-1:0] div_quot;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign row_lo    = ROW_W'(rowc_r);
  assign rowc_nxt  = (rowc_r == RC_W'(MAX_ROWS - 1)) ? '0 : rowc_r + 1'b1;
  assign k_last    = (CNT_W'(k_r) == count_r - CNT_W'(1));
  // A pass-through pixel is last unless a column end still has held pixels to flush.
  assign pix_last  = !cend_r || (count_r == '0) || (!land_r && pres_r);

  always_comb begin
    dv       = DV_W'(val_r) - DV_W'(left_val_r);
    dl       = DL_W'($signed(mem_rd_data.lat)) - DL_W'(left_lat_r);
    den_w    = DEN_W'(lat_r) - DEN_W'(left_lat_r);
    prod     = PROD_W'(dv) * PROD_W'(dl);
    prod_neg = -prod_r;
    den_neg  = -den_r;
    qs       = SUM_W'(div_quot);
    if (prod_r[PROD_W-1] ^ den_r[DEN_W-1]) begin
      qs = -qs;
    end
    sum = SUM_W'(left_val_r) + qs;
    if (sum > SUM_W'(VAL_MAX)) begin
      interp = VAL_MAX;
    end else if (sum < SUM_W'(VAL_MIN)) begin
      interp = VAL_MIN;
    end else begin
      interp = VAL_W'(sum);
    end
  end

  assign div_req.start = (state_r == S_GDIV);
  assign div_req.num   = prod_r[PROD_W-1] ? MAG_W'(prod_neg) : MAG_W'(prod_r);
  assign div_req.den   = den_r[DEN_W-1] ? DEN_W'(den_neg) : DEN_W'(den_r);

  assign mem_wr_en       = accept && !in_is_land && !in_value_present &&
                           (count_r != CNT_W'(MAX_GAP));
  assign mem_wr_data.row = row_lo;
  assign mem_wr_data.lat = in_latitude;
  assign mem_rd_en       = (state_r == S_GRD) || (state_r == S_FRD);

  cgli_gap_mem #(
    .DEPTH (MAX_GAP)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (k_r),
    .rd_data (mem_rd_data)
  );

  cgli_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rowc_r      <= '0;
      have_left_r <= 1'b0;
      left_val_r  <= '0;
      left_lat_r  <= '0;
      count_r     <= '0;
      k_r         <= '0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            val_r  <= in_pixel_value;
            pres_r <= in_value_present;
            lat_r  <= in_latitude;
            land_r <= in_is_land;
            cend_r <= in_column_end;
            row_r  <= row_lo;
            rowc_r <= in_column_end ? '0 : rowc_nxt;
            k_r    <= '0;
            if (in_is_land) begin
              state_r <= S_PIX;
            end else if (in_value_present) begin
              state_r <= (count_r != '0) ? S_GRD : S_PIX;
            end else if (count_r != CNT_W'(MAX_GAP)) begin
              count_r <= count_r + 1'b1;
              if (in_column_end) begin
                state_r <= S_FRD;
              end
            end else begin
              state_r <= S_PIX;
            end
          end
        end
        S_PIX: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_row_r   <= row_r;
            out_val_r   <= (pres_r && (land_r || pres_r)) ? val_r : '0;
            out_pres_r  <= pres_r;
            out_ovf_r   <= !land_r && !pres_r;
            out_last_r  <= pix_last;
            if (!land_r && pres_r) begin
              have_left_r <= 1'b1;
              left_val_r  <= val_r;
              left_lat_r  <= lat_r;
              count_r     <= '0;
            end
            if (pix_last) begin
              state_r <= S_IDLE;
              if (cend_r) begin
                have_left_r <= 1'b0;
                left_val_r  <= '0;
                left_lat_r  <= '0;
                count_r     <= '0;
              end
            end else begin
              state_r <= S_FRD;
            end
          end
        end
        S_GRD: begin
          state_r <= S_GMUL;
        end
        S_GMUL: begin
          if (!have_left_r) begin
            fill_r  <= val_r;
            state_r <= S_GOUT;
          end else if (den_w == '0) begin
            fill_r  <= left_val_r;
            state_r <= S_GOUT;
          end else begin
            prod_r  <= prod;
            den_r   <= den_w;
            state_r <= S_GDIV;
          end
        end
        S_GDIV: begin
          state_r <= S_GWAIT;
        end
        S_GWAIT: begin
          if (div_done) begin
            fill_r  <= interp;
            state_r <= S_GOUT;
          end
        end
        S_GOUT: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_row_r   <= mem_rd_data.row;
            out_val_r   <= fill_r;
            out_pres_r  <= 1'b1;
            out_ovf_r   <= 1'b0;
            out_last_r  <= 1'b0;
            if (k_last) begin
              state_r <= S_PIX;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_GRD;
            end
          end
        end
        S_FRD: begin
          state_r <= S_FOUT;
        end
        S_FOUT: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_row_r   <= mem_rd_data.row;
            out_val_r   <= have_left_r ? left_val_r : '0;
            out_pres_r  <= have_left_r;
            out_ovf_r   <= 1'b0;
            out_last_r  <= k_last;
            if (k_last) begin
              state_r     <= S_IDLE;
              have_left_r <= 1'b0;
              left_val_r  <= '0;
              left_lat_r  <= '0;
              count_r     <= '0;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_FRD;
            end
          end
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_row_index      = out_row_r;
  assign out_result_value   = out_val_r;
  assign out_result_present = out_pres_r;
  assign out_gap_overflow   = out_ovf_r;
  assign out_last_of_run    = out_last_r;

endmodule

// ===== rtl/cgli_checker.sv =====
// Port checker for the column gap interpolator and its bind.
`timescale 1ns / 1ps
module cgli_assertions (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input cgli_pkg::val_t in_pixel_value,
  input logic           in_value_present,
  input cgli_pkg::lat_t in_latitude,
  input logic           in_is_land,
  input logic           in_column_end,
  input logic           out_valid,
  input logic           out_ready,
  input cgli_pkg::row_t out_row_index,
  input cgli_pkg::val_t out_result_value,
  input logic           out_result_present,
  input logic           out_gap_overflow,
  input logic           out_last_of_run
);
  import cgli_pkg::*;

  // A missing result always carries a zero value.
  a_missing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_present |-> out_result_value == '0)
    else $error("missing result with nonzero value");

  // An overflowed pixel is never reported as filled.
  a_ovf_missing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_gap_overflow |-> !out_result_present)
    else $error("overflow word marked present");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row_index) &&
      $stable(out_result_value) && $stable(out_last_of_run))
    else $error("output word changed while stalled");

  // A waiting input word keeps its payload until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_pixel_value) &&
      $stable(in_value_present) && $stable(in_latitude) && $stable(in_is_land) &&
      $stable(in_column_end))
    else $error("input word changed while waiting");

  // No new item may enter while an earlier one is still producing results.
  a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> !in_ready)
    else $error("input taken while a run is incomplete");

endmodule

bind column_gap_linear_interpolator_core cgli_assertions u_cgli_checker (.*);

// ===== dv/cgli_checker.sv =====
// Checker for the column gap interpolator: predicts result words from accepted pixels.
`timescale 1ns / 1ps
module cgli_checker #(
  parameter int MAX_GAP  = 32,
  parameter int MAX_ROWS = 8192
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  cgli_pkg::val_t in_pixel_value,
  input  logic           in_value_present,
  input  cgli_pkg::lat_t in_latitude,
  input  logic           in_is_land,
  input  logic           in_column_end,
  input  logic           out_valid,
  input  logic           out_ready,
  input  cgli_pkg::row_t out_row_index,
  input  cgli_pkg::val_t out_result_value,
  input  logic           out_result_present,
  input  logic           out_gap_overflow,
  input  logic           out_last_of_run,
  output int             fail_count,
  output int             pending_results,
  output int             filled_count,
  output int             flushed_count,
  output int             overflow_count
);
  import cgli_pkg::*;

  typedef struct packed {
    row_t row;
    val_t value;
    logic present;
    logic ovf;
    logic last;
  } result_word_t;

  result_word_t expected_words[$];

  // Predictor state.
  row_t         next_row;
  logic         left_valid;
  longint       left_lat;
  longint       left_val;
  int           held_count;
  row_t         held_rows[MAX_GAP];
  longint       held_lats[MAX_GAP];

  function automatic longint interp_value(longint rval, longint rlat, longint x);
    longint den;
    longint num;
    longint sum;
    if (!left_valid) return rval;
    den = rlat - left_lat;
    if (den == 0) return left_val;
    num = (rval - left_val) * (x - left_lat);
    sum = left_val + num / den;  // SV division truncates toward zero
    if (sum > longint'(VAL_MAX)) return longint'(VAL_MAX);
    if (sum < longint'(VAL_MIN)) return longint'(VAL_MIN);
    return sum;
  endfunction

  function automatic void push_word(row_t r, longint v, logic p, logic o);
    result_word_t w;
    w.row     = r;
    w.value   = p ? val_t'(v) : '0;
    w.present = p;
    w.ovf     = o;
    w.last    = 1'b0;
    expected_words.push_back(w);
  endfunction

  task automatic predict_pixel();
    int     n0;
    longint v;
    longint lat;
    row_t   r;
    n0  = expected_words.size();
    v   = longint'(in_pixel_value);
    lat = longint'(in_latitude);
    r   = next_row;
    if (in_is_land) begin
      push_word(r, v, in_value_present, 1'b0);
    end else if (in_value_present) begin
      for (int k = 0; k < held_count; k++) begin
        push_word(held_rows[k], interp_value(v, lat, held_lats[k]), 1'b1, 1'b0);
        filled_count++;
      end
      held_count = 0;
      push_word(r, v, 1'b1, 1'b0);
      left_valid = 1'b1;
      left_lat   = lat;
      left_val   = v;
    end else if (held_count < MAX_GAP) begin
      held_rows[held_count] = r;
      held_lats[held_count] = lat;
      held_count++;
    end else begin
      push_word(r, 0, 1'b0, 1'b1);
      overflow_count++;
    end
    next_row = row_t'((int'(r) + 1) % MAX_ROWS);
    if (in_column_end) begin
      for (int k = 0; k < held_count; k++) begin
        push_word(held_rows[k], left_val, left_valid, 1'b0);
        flushed_count++;
      end
      held_count = 0;
      left_valid = 1'b0;
      left_lat   = 0;
      left_val   = 0;
      next_row   = '0;
    end
    if (expected_words.size() > n0) expected_words[$].last = 1'b1;
  endtask

  always @(posedge clk) begin
    result_word_t e;
    if (!rst_n) begin
      expected_words.delete();
      next_row        = '0;
      left_valid      = 1'b0;
      left_lat        = 0;
      left_val        = 0;
      held_count      = 0;
      fail_count     <= 0;
      filled_count    = 0;
      flushed_count   = 0;
      overflow_count  = 0;
    end else begin
      // Check the output first: a word cannot be caused by a pixel taken this edge.
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("%0t: unexpected word row=%0d value=%0d", $realtime, out_row_index,
                     out_result_value);
        end else begin
          e = expected_words.pop_front();
          if (e.row !== out_row_index || e.value !== out_result_value ||
              e.present !== out_result_present || e.ovf !== out_gap_overflow ||
              e.last !== out_last_of_run) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display({"%0t: mismatch exp row=%0d val=%0d p=%0b ovf=%0b last=%0b",
                        " / got row=%0d val=%0d p=%0b ovf=%0b last=%0b"},
                       $realtime, e.row, e.value, e.present, e.ovf, e.last, out_row_index,
                       out_result_value, out_result_present, out_gap_overflow,
                       out_last_of_run);
          end
        end
      end
      if (in_valid && in_ready) predict_pixel();
    end
  end

  assign pending_results = expected_words.size();

endmodule

// ===== dv/column_gap_linear_interpolator_core_tb.sv =====
// Testbench top: pixel stimulus, output back-pressure, watchdog and verdict.
`timescale 1ns / 1ps
module column_gap_linear_interpolator_core_tb;
  import cgli_pkg::*;

  localparam int MAX_GAP     = 32;
  localparam int MAX_ROWS    = 8192;
  localparam int RANDOM_COLS = 20;
  localparam int QUIET_ITEMS = 60;
  localparam int WATCHDOG    = 20000;
  localparam int LAT_MAXV    = 90000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  val_t in_pixel_value = '0;
  logic in_value_present = 1'b0;
  lat_t in_latitude = '0;
  logic in_is_land = 1'b0;
  logic in_column_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  row_t out_row_index;
  val_t out_result_value;
  logic out_result_present;
  logic out_gap_overflow;
  logic out_last_of_run;

  int fail_count, pending_results, filled_count, flushed_count, overflow_count;
  int sent_items = 0;
  bit idle_on = 1'b1;
  bit hold_output = 1'b0;
  int quiet_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  column_gap_linear_interpolator_core #(.MAX_GAP(MAX_GAP), .MAX_ROWS(MAX_ROWS)) u_top (
    .clk, .rst_n, .in_valid, .in_ready, .in_pixel_value, .in_value_present, .in_latitude,
    .in_is_land, .in_column_end, .out_valid, .out_ready, .out_row_index, .out_result_value,
    .out_result_present, .out_gap_overflow, .out_last_of_run
  );

  cgli_checker #(.MAX_GAP(MAX_GAP), .MAX_ROWS(MAX_ROWS)) u_checker (.*);

  // Sends one pixel word and waits for it to be taken. Valid stays high into the
  // next call so that words can follow back to back.
  task automatic send_pixel(val_t v, logic p, lat_t lat, logic land, logic cend);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_pixel_value   <= v;
    in_value_present <= p;
    in_latitude      <= lat;
    in_is_land       <= land;
    in_column_end    <= cend;
    do @(posedge clk); while (!in_ready);
    sent_items++;
  endtask

  function automatic lat_t rand_lat();
    return lat_t'(int'($urandom_range(0, 2 * LAT_MAXV)) - LAT_MAXV);
  endfunction

  function automatic val_t rand_val();
    case ($urandom_range(0, 3))
      0: return VAL_MAX;
      1: return VAL_MIN;
      default: return val_t'($urandom);
    endcase
  endfunction

  // One random column: mostly valid ocean with gaps, some land and noise.
  task automatic send_column(int len, int gap_max);
    int   lat0;
    int   step;
    int   kind;
    lat0 = int'($urandom_range(0, 2 * LAT_MAXV)) - LAT_MAXV;
    step = int'($urandom_range(0, 2000000)) - 1000000;
    for (int i = 0; i < len; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 3 && gap_max > 0) begin
        repeat ($urandom_range(1, gap_max))
          send_pixel(val_t'($urandom), 1'b0, lat_t'(lat0 + i * step + int'($urandom_range(0, 99))),
                     1'b0, 1'b0);
      end else if (kind == 3) begin
        send_pixel(rand_val(), $urandom_range(0, 1), rand_lat(), 1'b1, 1'b0);
      end else if (kind == 4) begin
        send_pixel(rand_val(), 1'b1, rand_lat(), 1'b0, 1'b0);
      end else begin
        send_pixel(val_t'($urandom), 1'b1, lat_t'(lat0 + i * step), 1'b0, 1'b0);
      end
    end
    send_pixel(val_t'($urandom), $urandom_range(0, 1), rand_lat(), $urandom_range(0, 1), 1'b1);
  endtask

  // Output back-pressure: random stall bursts, one long hold, none when quiet.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      quiet_cycles <= 0;
    end else if (hold_output) begin
      out_ready <= 1'b0;
    end else if (quiet_cycles > 0) begin
      out_ready <= 1'b0;
      quiet_cycles <= quiet_cycles - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      quiet_cycles <= $urandom_range(0, 9);
    end else begin
      out_ready <= 1'b1;
    end
  end

  int stuck_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || hold_output) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG) begin
      $display("watchdog: no word moved for %0d cycles", WATCHDOG);
      $display("** column_gap_linear_interpolator_core: FAILED **");
      $finish;
    end
  end

  initial begin
    int drain;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, land, no left neighbour, equal latitudes, extrapolation.
    send_pixel('0, 1'b0, lat_t'(-LAT_MAXV), 1'b0, 1'b0);
    send_pixel(VAL_MAX, 1'b1, lat_t'(LAT_MAXV), 1'b0, 1'b0);
    send_pixel(VAL_MIN, 1'b1, lat_t'(-LAT_MAXV), 1'b1, 1'b0);
    send_pixel(VAL_MAX, 1'b0, lat_t'(5), 1'b1, 1'b0);
    send_pixel('0, 1'b0, lat_t'(7), 1'b0, 1'b0);
    send_pixel(VAL_MIN, 1'b1, lat_t'(LAT_MAXV), 1'b0, 1'b0);
    send_pixel('0, 1'b0, lat_t'(-LAT_MAXV), 1'b0, 1'b0);
    send_pixel(VAL_MAX, 1'b1, lat_t'(LAT_MAXV - 1), 1'b0, 1'b0);
    send_pixel('0, 1'b0, lat_t'(-LAT_MAXV), 1'b0, 1'b0);
    send_pixel(VAL_MIN, 1'b1, lat_t'(LAT_MAXV), 1'b0, 1'b0);
    send_pixel('0, 1'b0, lat_t'(12), 1'b0, 1'b0);
    send_pixel('0, 1'b0, lat_t'(13), 1'b0, 1'b1);
    send_pixel('0, 1'b0, lat_t'(1), 1'b0, 1'b0);
    send_pixel('0, 1'b0, lat_t'(2), 1'b0, 1'b1);
    send_pixel(24'sh000100, 1'b1, lat_t'(-1), 1'b1, 1'b1);
    // Full gap buffer plus overflow, with the output held so the input stalls.
    hold_output <= 1'b1;
    fork
      begin
        repeat (MAX_GAP + 3) send_pixel(val_t'($urandom), 1'b0, rand_lat(), 1'b0, 1'b0);
        send_pixel(24'sh123456, 1'b1, rand_lat(), 1'b0, 1'b0);
        send_column(12, 3);
      end
      begin repeat (300) @(posedge clk); hold_output <= 1'b0; end
    join

    // Random columns; one long one carries big gaps and overflow.
    for (int c = 0; c < RANDOM_COLS; c++) begin
      if (c % 15 == 7) send_column($urandom_range(10, 20), 40);
      else send_column($urandom_range(1, 8), 4);
    end
    // A long column walks the row counter up.
    for (int i = 0; i < 60; i++) send_pixel(val_t'($urandom), 1'b1, rand_lat(), 1'b0, 1'b0);
    send_pixel('0, 1'b1, '0, 1'b0, 1'b1);

    idle_on = 1'b0;
    for (int c = 0; c < QUIET_ITEMS / 6; c++) send_column(4, 3);
    in_valid <= 1'b0;

    drain = 0;
    while (pending_results > 0 && drain < 100000) begin
      @(posedge clk);
      drain++;
    end
    repeat (200) @(posedge clk);
    $display("Sent %0d pixels; %0d interpolated, %0d flushed, %0d overflowed.", sent_items,
             filled_count, flushed_count, overflow_count);
    if (fail_count == 0 && pending_results == 0) begin
      $display("** column_gap_linear_interpolator_core: PASSED **");
    end else begin
      $display("%0d mismatches, %0d words still expected.", fail_count, pending_results);
      $display("** column_gap_linear_interpolator_core: FAILED **");
    end
    $finish;
  end

endmodule
